// ----- hdl/kcg_pkg.sv -----
// Package for the k-combination generator: widths, limits, sequencer codes
// and the control store. Used by the channel interfaces and the top level.
package kcg_pkg;

    localparam int MAX_N = 32;
    localparam int MAX_K = 8;

    localparam int N_W        = 6;
    localparam int K_W        = 4;
    localparam int POS_W      = 3;
    localparam int LIM_W      = N_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int UPC_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHOOSE_COUNT = 1'd1;

    localparam logic [N_W-1:0] MAX_VALUE_RST    = 6'd4;
    localparam logic [K_W-1:0] CHOOSE_COUNT_RST = 4'd2;

    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t U_WAIT      = 4'd0;
    localparam upc_t U_CHK_EMPTY = 4'd1;
    localparam upc_t U_CHK_START = 4'd2;
    localparam upc_t U_INIT      = 4'd3;
    localparam upc_t U_SEARCH    = 4'd4;
    localparam upc_t U_INC       = 4'd5;
    localparam upc_t U_REFILL    = 4'd6;
    localparam upc_t U_EMIT_SET  = 4'd7;
    localparam upc_t U_EMIT      = 4'd8;
    localparam upc_t U_DONE      = 4'd9;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_CHK_EMPTY,
        OP_CHK_START,
        OP_INIT,
        OP_SEARCH,
        OP_INC,
        OP_REFILL,
        OP_EMIT_SET,
        OP_EMIT,
        OP_DONE
    } op_t;

    typedef enum logic [1:0] {
        SEL_STAY,
        SEL_NEXT,
        SEL_BRANCH
    } seq_sel_t;

    typedef enum logic [1:0] {
        WS_INIT,
        WS_INC,
        WS_REFILL
    } wsel_t;

    typedef struct packed {
        op_t  op;
        upc_t next;
        upc_t branch;
    } ctrl_t;

    typedef struct packed {
        logic  ptr_ld_zero;
        logic  ptr_ld_last;
        logic  ptr_inc;
        logic  ptr_dec;
        logic  comb_we;
        wsel_t wsel;
        logic  set_started;
        logic  set_exhausted;
        logic  clr_flags;
        logic  res_load;
        logic  res_done;
    } dp_ctl_t;

    // control store
    function automatic ctrl_t ucode(input upc_t upc);
        ctrl_t c;
        case (upc)
            U_WAIT:      c = '{OP_WAIT,      U_WAIT,      U_CHK_EMPTY};
            U_CHK_EMPTY: c = '{OP_CHK_EMPTY, U_CHK_START, U_DONE};
            U_CHK_START: c = '{OP_CHK_START, U_INIT,      U_SEARCH};
            U_INIT:      c = '{OP_INIT,      U_INIT,      U_EMIT_SET};
            U_SEARCH:    c = '{OP_SEARCH,    U_DONE,      U_INC};
            U_INC:       c = '{OP_INC,       U_REFILL,    U_EMIT_SET};
            U_REFILL:    c = '{OP_REFILL,    U_REFILL,    U_EMIT_SET};
            U_EMIT_SET:  c = '{OP_EMIT_SET,  U_EMIT,      U_EMIT};
            U_EMIT:      c = '{OP_EMIT,      U_EMIT,      U_WAIT};
            U_DONE:      c = '{OP_DONE,      U_DONE,      U_WAIT};
            default:     c = '{OP_WAIT,      U_WAIT,      U_WAIT};
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/kcg_if.sv -----
// Channel interfaces for request and result beats (valid/ready).
// Depends on kcg_pkg for field widths.
interface kcg_req_if;
    import kcg_pkg::*;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface kcg_res_if;
    import kcg_pkg::*;
    logic             valid;
    logic             ready;
    logic [N_W-1:0]   element;
    logic [POS_W-1:0] position;
    logic             last;
    logic             done_res;
    modport source (output valid, output element, output position, output last,
                    output done_res, input ready);
    modport sink (input valid, input element, input position, input last,
                  input done_res, output ready);
endinterface

// ----- hdl/k_combination_generator.sv -----
// Lexicographic k-combination generator: microcoded sequencer over a small
// register file of positions. Depends on kcg_pkg and kcg_if.
// A first request fills the positions; an advance searches from the last position down
//   and refills to the right; a done result follows when the search runs out.
// Throughput (ready held): one beat per cycle while a combination is emitted.
// Reset: n=4, k=2, enumeration restarts; no clearing pass, positions written before read.
module k_combination_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kcg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kcg_pkg::CFG_DATA_W-1:0]  cfg_data,
    kcg_req_if.sink                         req,
    kcg_res_if.source                       res
);
    import kcg_pkg::*;

    logic [N_W-1:0]   max_value_reg;
    logic [K_W-1:0]   choose_count_reg;
    upc_t             upc_reg, upc_next;
    logic [POS_W-1:0] ptr_reg, ptr_next;
    logic [N_W-1:0]   val_reg;
    logic [N_W-1:0]   comb_reg [MAX_K];
    logic             started_reg, exhausted_reg;
    logic             res_valid_reg;
    logic [N_W-1:0]   elem_reg;
    logic [POS_W-1:0] pos_reg;
    logic             last_reg, done_reg;

    logic [N_W-1:0]   n_eff;
    logic [K_W-1:0]   k_eff;
    logic [POS_W-1:0] k_last;
    logic             empty;
    logic [LIM_W-1:0] limit;
    logic [N_W-1:0]   comb_rd;
    logic             hit;
    logic             at_last;
    logic             slot_free;
    logic             req_beat;
    logic [N_W-1:0]   wr_val;
    ctrl_t            ctrl;
    seq_sel_t         sel;
    dp_ctl_t          dp;

    assign n_eff   = (max_value_reg > N_W'(MAX_N)) ? N_W'(MAX_N) : max_value_reg;
    assign k_eff   = (choose_count_reg > K_W'(MAX_K)) ? K_W'(MAX_K) : choose_count_reg;
    assign k_last  = POS_W'(k_eff - K_W'(1));
    assign empty   = (k_eff == '0) || ({{(N_W-K_W){1'b0}}, k_eff} > n_eff);
    assign comb_rd = comb_reg[ptr_reg];
    assign limit   = {1'b0, n_eff} - LIM_W'(k_eff) + LIM_W'(1) + LIM_W'(ptr_reg);
    assign hit     = {1'b0, comb_rd} < limit;
    assign at_last = (ptr_reg == k_last);

    assign ctrl      = ucode(upc_reg);
    assign slot_free = !res_valid_reg || res.ready;
    assign req_beat  = req.valid && req.ready;
    assign req.ready = (ctrl.op == OP_WAIT);

    // control word decode
    always_comb
    begin
        sel = SEL_STAY;
        dp  = '0;
        dp.wsel = WS_INIT;
        case (ctrl.op)
            OP_WAIT:
            begin
                if (req.valid)
                begin
                    sel          = SEL_BRANCH;
                    dp.clr_flags = req.restart;
                end
            end
            OP_CHK_EMPTY:
            begin
                sel = (empty || exhausted_reg) ? SEL_BRANCH : SEL_NEXT;
            end
            OP_CHK_START:
            begin
                if (started_reg)
                begin
                    sel            = SEL_BRANCH;
                    dp.ptr_ld_last = 1'b1;
                end
                else
                begin
                    sel            = SEL_NEXT;
                    dp.ptr_ld_zero = 1'b1;
                end
            end
            OP_INIT:
            begin
                dp.comb_we     = 1'b1;
                dp.wsel        = WS_INIT;
                dp.set_started = 1'b1;
                sel            = at_last ? SEL_BRANCH : SEL_STAY;
                dp.ptr_inc     = !at_last;
            end
            OP_SEARCH:
            begin
                if (hit)
                    sel = SEL_BRANCH;
                else if (ptr_reg == '0)
                    sel = SEL_NEXT;
                else
                    dp.ptr_dec = 1'b1;
            end
            OP_INC:
            begin
                dp.comb_we = 1'b1;
                dp.wsel    = WS_INC;
                sel        = at_last ? SEL_BRANCH : SEL_NEXT;
                dp.ptr_inc = !at_last;
            end
            OP_REFILL:
            begin
                dp.comb_we = 1'b1;
                dp.wsel    = WS_REFILL;
                sel        = at_last ? SEL_BRANCH : SEL_STAY;
                dp.ptr_inc = !at_last;
            end
            OP_EMIT_SET:
            begin
                dp.ptr_ld_zero = 1'b1;
                sel            = SEL_NEXT;
            end
            OP_EMIT:
            begin
                if (slot_free)
                begin
                    dp.res_load = 1'b1;
                    sel         = at_last ? SEL_BRANCH : SEL_STAY;
                    dp.ptr_inc  = !at_last;
                end
            end
            OP_DONE:
            begin
                if (slot_free)
                begin
                    dp.res_load      = 1'b1;
                    dp.res_done      = 1'b1;
                    dp.set_exhausted = 1'b1;
                    sel              = SEL_BRANCH;
                end
            end
            default:
            begin
                sel = SEL_STAY;
            end
        endcase
    end

    // step counter
    always_comb
    begin
        case (sel)
            SEL_NEXT:   upc_next = ctrl.next;
            SEL_BRANCH: upc_next = ctrl.branch;
            default:    upc_next = upc_reg;
        endcase
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (dp.ptr_ld_zero)
            ptr_next = '0;
        else if (dp.ptr_ld_last)
            ptr_next = k_last;
        else if (dp.ptr_inc)
            ptr_next = ptr_reg + POS_W'(1);
        else if (dp.ptr_dec)
            ptr_next = ptr_reg - POS_W'(1);
    end

    always_comb
    begin
        case (dp.wsel)
            WS_INC:    wr_val = comb_rd + N_W'(1);
            WS_REFILL: wr_val = val_reg + N_W'(1);
            default:   wr_val = N_W'(ptr_reg) + N_W'(1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg    <= MAX_VALUE_RST;
            choose_count_reg <= CHOOSE_COUNT_RST;
            upc_reg          <= U_WAIT;
            ptr_reg          <= '0;
            started_reg      <= 1'b0;
            exhausted_reg    <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            ptr_reg <= ptr_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_VALUE:    max_value_reg    <= cfg_data;
                    CFG_CHOOSE_COUNT: choose_count_reg <= cfg_data[K_W-1:0];
                    default:          max_value_reg    <= max_value_reg;
                endcase
                started_reg   <= 1'b0;
                exhausted_reg <= 1'b0;
            end
            else if (dp.clr_flags)
            begin
                started_reg   <= 1'b0;
                exhausted_reg <= 1'b0;
            end
            else
            begin
                if (dp.set_started)
                    started_reg <= 1'b1;
                if (dp.set_exhausted)
                    exhausted_reg <= 1'b1;
            end
            if (dp.res_load)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp.comb_we)
        begin
            comb_reg[ptr_reg] <= wr_val;
            val_reg           <= wr_val;
        end
        if (dp.res_load)
        begin
            elem_reg <= dp.res_done ? '0 : comb_rd;
            pos_reg  <= dp.res_done ? '0 : ptr_reg;
            last_reg <= dp.res_done || at_last;
            done_reg <= dp.res_done;
        end
    end

    assign res.valid    = res_valid_reg;
    assign res.element  = elem_reg;
    assign res.position = pos_reg;
    assign res.last     = last_reg;
    assign res.done_res = done_reg;

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == U_EMIT) |-> ({1'b0, ptr_reg} < k_eff))
        else $error("emit position beyond k");

    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && done_reg) |-> (last_reg && elem_reg == '0 && pos_reg == '0))
        else $error("malformed done beat");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (req_beat && req.restart) |=> (!started_reg && !exhausted_reg))
        else $error("restart did not clear enumeration state");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == U_SEARCH) |-> ({1'b0, comb_rd} <= limit))
        else $error("position above its limit");

endmodule

// ----- tb/kcg_combination_checker.sv -----
`timescale 1ns / 100ps
// Checker for the k-combination generator: tracks register writes and request
// beats, predicts the element beats of each request and compares result beats.
// Depends on kcg_pkg and the channel interfaces in kcg_if.
module kcg_combination_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kcg_pkg::CFG_DATA_W-1:0] cfg_data,
    kcg_req_if                             req,
    kcg_res_if                             res,
    output int                             fail_count,
    output int                             pending,
    output int                             beats_seen
);
    import kcg_pkg::*;

    typedef struct packed {
        logic [N_W-1:0]   element;
        logic [POS_W-1:0] position;
        logic             last;
        logic             done_res;
    } elem_beat_t;

    elem_beat_t       element_q [$];
    logic [N_W-1:0]   set_size;
    logic [K_W-1:0]   pick_count;
    logic [N_W-1:0]   combo [MAX_K];
    logic             started;
    logic             exhausted;

    task automatic queue_done();
        elem_beat_t b;
        b.element  = '0;
        b.position = '0;
        b.last     = 1'b1;
        b.done_res = 1'b1;
        element_q  = {element_q, b};
    endtask

    task automatic queue_combo(input int k);
        elem_beat_t b;
        for (int i = 0; i < k; i++)
        begin
            b.element  = combo[i];
            b.position = POS_W'(i);
            b.last     = (i == k - 1);
            b.done_res = 1'b0;
            element_q  = {element_q, b};
        end
    endtask

    // successor rule: bump the rightmost position below its limit, refill to the right
    task automatic next_combination(input logic restart);
        int n;
        int k;
        int i;
        n = (set_size > MAX_N) ? MAX_N : int'(set_size);
        k = (pick_count > MAX_K) ? MAX_K : int'(pick_count);
        if (restart)
        begin
            started   = 1'b0;
            exhausted = 1'b0;
        end
        if (k == 0 || k > n)
            exhausted = 1'b1;
        if (exhausted)
            queue_done();
        else if (!started)
        begin
            for (i = 0; i < k; i++)
                combo[i] = N_W'(i + 1);
            started = 1'b1;
            queue_combo(k);
        end
        else
        begin
            i = k;
            while (i > 0 && int'(combo[i-1]) >= n - k + i)
                i--;
            if (i == 0)
            begin
                exhausted = 1'b1;
                queue_done();
            end
            else
            begin
                combo[i-1] = combo[i-1] + 1'b1;
                for (int j = i; j < k; j++)
                    combo[j] = combo[j-1] + 1'b1;
                queue_combo(k);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        elem_beat_t want;
        elem_beat_t got;
        if (!rst_n)
        begin
            element_q.delete();
            set_size   = MAX_VALUE_RST;
            pick_count = CHOOSE_COUNT_RST;
            started    = 1'b0;
            exhausted  = 1'b0;
            fail_count = 0;
            beats_seen = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_VALUE:    set_size   = cfg_data[N_W-1:0];
                    CFG_CHOOSE_COUNT: pick_count = cfg_data[K_W-1:0];
                    default:          ;
                endcase
                started   = 1'b0;
                exhausted = 1'b0;
            end
            if (res.valid && res.ready)
            begin
                got = '{res.element, res.position, res.last, res.done_res};
                beats_seen++;
                if (element_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected beat: element %0d position %0d last %0b done %0b",
                                 $time, got.element, got.position, got.last, got.done_res);
                end
                else
                begin
                    want = element_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: expected element %0d position %0d last %0b done %0b",
                                     $time, want.element, want.position, want.last,
                                     want.done_res);
                            $display("%0t:      got element %0d position %0d last %0b done %0b",
                                     $time, got.element, got.position, got.last,
                                     got.done_res);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
                next_combination(req.restart);
            pending = element_q.size();
        end
    end

endmodule

// ----- tb/tb_k_combination_generator.sv -----
`timescale 1ns / 100ps
// Top of the k-combination generator testbench: clock, reset, register writes,
// request and ready stimulus, watchdog and verdict. Uses kcg_combination_checker.
module tb_k_combination_generator;
    import kcg_pkg::*;

    localparam int IDLE_NONE      = 0;
    localparam int IDLE_SENDER    = 1;
    localparam int IDLE_RECEIVER  = 2;
    localparam int IDLE_BOTH      = 3;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int beats_seen;
    int idle_mode;
    int requests_sent;
    int settings_written;
    int quiet_cycles;

    kcg_req_if req_ch ();
    kcg_res_if res_ch ();

    k_combination_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    kcg_combination_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .beats_seen (beats_seen)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles, %0d result beats outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        int stall_pct;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall_pct = (idle_mode == IDLE_RECEIVER) ? 49 : (idle_mode == IDLE_BOTH) ? 8 : 0;
            res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic rs);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 49 : (idle_mode == IDLE_BOTH) ? 8 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.restart <= rs;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] n_val,
                                  input logic [CFG_DATA_W-1:0] k_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_VALUE;
        cfg_data  <= n_val;
        @(negedge clk);
        cfg_index <= CFG_CHOOSE_COUNT;
        cfg_data  <= k_val;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    initial
    begin
        int n_pick;
        int k_pick;
        logic [CFG_DATA_W-1:0] k_val;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.restart   = 1'b0;
        idle_mode        = IDLE_NONE;
        requests_sent    = 0;
        settings_written = 0;
        quiet_cycles     = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings n=4 k=2: all six, the done beat, done after the end, restart
        repeat (8) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        settle();
        write_settings(6'd0, 6'd2);         // empty set
        send_request(1'b0);
        settle();
        write_settings(6'd63, 6'h3F);       // both clamp: n=32, k=8
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        settle();
        write_settings(6'd7, 6'd0);         // k of zero
        send_request(1'b0);
        settle();
        write_settings(6'd5, 6'd5);         // single combination
        send_request(1'b0);
        send_request(1'b0);
        settle();
        write_settings(6'd3, 6'h24);        // k=4 above n, upper data bits set
        send_request(1'b0);
        settle();
        write_settings(6'd1, 6'd1);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        settle();

        for (int phase = 0; phase < 8; phase++)
        begin
            idle_mode = phase % 4;
            if (phase == 2)
            begin
                n_pick = MAX_N;
                k_pick = MAX_K;
            end
            else if (phase == 5)
            begin
                n_pick = $urandom_range(33, 63);
                k_pick = $urandom_range(9, 15);
            end
            else
            begin
                n_pick = $urandom_range(1, 8);
                k_pick = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(1, n_pick);
            end
            k_val = {2'($urandom_range(0, 3)), 4'(k_pick)};
            write_settings(6'(n_pick), k_val);
            for (int item = 0; item < 19; item++)
                send_request($urandom_range(0, 11) == 0);
            settle();
        end

        idle_mode = IDLE_NONE;
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        $display("Sent %0d requests and checked %0d result beats over %0d register settings,",
                 requests_sent, beats_seen, settings_written);
        $display("with clamped sizes, empty choices, restarts and all four idle patterns.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
